// ----- rtl/cct_pkg.sv -----
package cct_pkg;

    localparam int TICK_W    = 10;
    localparam int PRESET_W  = 7;
    localparam int CD_W      = 7;
    localparam int HOUR_W    = 4;
    localparam int MIN_W     = 6;
    localparam int SEC_W     = 6;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 10;

    localparam logic [TICK_W-1:0]   TICKS_PER_SECOND_RESET = 10'd1000;
    localparam logic [PRESET_W-1:0] COUNTDOWN_PRESET_RESET = 7'd5;
    localparam logic [CD_W-1:0]     COUNTDOWN_RESET        = 7'd5;
    localparam logic [SEC_W-1:0]    LAST_SECOND            = 6'd59;
    localparam logic [MIN_W-1:0]    LAST_MINUTE            = 6'd59;
    localparam logic [HOUR_W-1:0]   LAST_HOUR              = 4'd12;
    localparam logic [HOUR_W-1:0]   FIRST_HOUR             = 4'd1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TICKS_PER_SECOND = 1'b0,
        CFG_COUNTDOWN_PRESET = 1'b1
    } cfg_index_t;

    typedef enum logic {
        ACT_TICK   = 1'b0,
        ACT_SWITCH = 1'b1
    } action_t;

    typedef enum logic [1:0] {
        CD_ENDED   = 2'd0,
        CD_RUNNING = 2'd1,
        CD_PAUSED  = 2'd2
    } cd_status_t;

    typedef struct packed {
        logic action;
        logic switch_level;
    } cct_in_t;

    typedef struct packed {
        logic [CD_W-1:0]   countdown_seconds;
        logic [1:0]        countdown_status;
        logic [HOUR_W-1:0] clock_hours;
        logic [MIN_W-1:0]  clock_minutes;
        logic [SEC_W-1:0]  clock_seconds;
    } cct_out_t;

endpackage

// ----- rtl/clock_and_countdown_timer.sv -----
// Twelve-hour clock (starting 12:00:00) with a countdown timer. Each accepted word is a
// millisecond tick or a switch sample, and gives exactly one result word carrying the
// countdown, its status and the clock time after that word. One word is taken every
// cycle while s_ready is high; it goes into the input register, and its result is
// presented on m_data from the result register behind the single update stage. While a
// result waits on m_ready the input register holds one more word, and s_ready drops until
// the result is taken. Configuration (ticks per second, countdown preset) must be written
// through cfg_we/cfg_index/cfg_data while no word is in flight; the block does not enforce it.
module clock_and_countdown_timer (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  cct_pkg::cct_in_t                   s_data,
    output logic                               m_valid,
    input  logic                               m_ready,
    output cct_pkg::cct_out_t                  m_data,
    input  logic                               cfg_we,
    input  logic [cct_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [cct_pkg::CFG_DATA_W-1:0]     cfg_data
);

    logic [cct_pkg::TICK_W-1:0]   tps_reg;
    logic [cct_pkg::PRESET_W-1:0] preset_reg;

    logic                         in_valid_reg;
    cct_pkg::cct_in_t             in_data_reg;
    logic                         out_valid_reg;
    cct_pkg::cct_out_t            out_data_reg;

    logic [cct_pkg::TICK_W-1:0]   tick_reg,    tick_next;
    logic [cct_pkg::SEC_W-1:0]    sec_reg,     sec_next;
    logic [cct_pkg::MIN_W-1:0]    min_reg,     min_next;
    logic [cct_pkg::HOUR_W-1:0]   hour_reg,    hour_next;
    logic [cct_pkg::CD_W-1:0]     cd_reg,      cd_next;
    logic                         running_reg, running_next;
    logic                         prev_sw_reg, prev_sw_next;

    cct_pkg::cd_status_t          status;
    cct_pkg::cct_out_t            result;
    logic [cct_pkg::TICK_W:0]     tick_inc;
    logic                         advance;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;
    assign tick_inc = {1'b0, tick_reg} + {{cct_pkg::TICK_W{1'b0}}, 1'b1};

    // configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tps_reg    <= cct_pkg::TICKS_PER_SECOND_RESET;
            preset_reg <= cct_pkg::COUNTDOWN_PRESET_RESET;
        end else if (cfg_we) begin
            unique case (cct_pkg::cfg_index_t'(cfg_index))
                cct_pkg::CFG_TICKS_PER_SECOND: tps_reg <= cfg_data;
                cct_pkg::CFG_COUNTDOWN_PRESET:
                    preset_reg <= cfg_data[cct_pkg::PRESET_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        tick_next    = tick_reg;
        sec_next     = sec_reg;
        min_next     = min_reg;
        hour_next    = hour_reg;
        cd_next      = cd_reg;
        running_next = running_reg;
        prev_sw_next = prev_sw_reg;

        if (in_data_reg.action == cct_pkg::ACT_TICK) begin
            if (tick_inc >= {1'b0, tps_reg}) begin
                tick_next = '0;
                if (sec_reg >= cct_pkg::LAST_SECOND) begin
                    sec_next = '0;
                    if (min_reg >= cct_pkg::LAST_MINUTE) begin
                        min_next = '0;
                        hour_next = (hour_reg >= cct_pkg::LAST_HOUR) ? cct_pkg::FIRST_HOUR
                                                                     : hour_reg + 4'd1;
                    end else begin
                        min_next = min_reg + 6'd1;
                    end
                end else begin
                    sec_next = sec_reg + 6'd1;
                end
                if (running_reg && cd_reg != '0) begin
                    cd_next = cd_reg - 7'd1;
                    if (cd_reg == 7'd1) begin
                        running_next = 1'b0;
                    end
                end
            end else begin
                tick_next = tick_inc[cct_pkg::TICK_W-1:0];
            end
        end else begin
            // falling edge of the switch toggles run/pause
            if (prev_sw_reg && !in_data_reg.switch_level) begin
                if (running_reg) begin
                    running_next = 1'b0;
                end else begin
                    if (cd_reg == '0) begin
                        cd_next = preset_reg;
                    end
                    running_next = 1'b1;
                end
            end
            prev_sw_next = in_data_reg.switch_level;
        end
    end

    always_comb begin
        if (cd_next == '0) begin
            status = cct_pkg::CD_ENDED;
        end else if (running_next) begin
            status = cct_pkg::CD_RUNNING;
        end else begin
            status = cct_pkg::CD_PAUSED;
        end
        result.countdown_seconds = cd_next;
        result.countdown_status  = status;
        result.clock_hours       = hour_next;
        result.clock_minutes     = min_next;
        result.clock_seconds     = sec_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            tick_reg      <= '0;
            sec_reg       <= '0;
            min_reg       <= '0;
            hour_reg      <= cct_pkg::LAST_HOUR;
            cd_reg        <= cct_pkg::COUNTDOWN_RESET;
            running_reg   <= 1'b0;
            prev_sw_reg   <= 1'b1;
        end else begin
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
                tick_reg      <= tick_next;
                sec_reg       <= sec_next;
                min_reg       <= min_next;
                hour_reg      <= hour_next;
                cd_reg        <= cd_next;
                running_reg   <= running_next;
                prev_sw_reg   <= prev_sw_next;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
        if (advance) begin
            out_data_reg <= result;
        end
    end

endmodule
